### rtl/core/bdu_pkg.sv
// Shared constants, types and helper functions for the BCD date/time converter.
package bdu_pkg;

   // Number of register stages from request to response.
   localparam int NSTG = 10;

   localparam logic [31:0] EPOCH_2000 = 32'd946684800;
   localparam logic [31:0] END_2100 = 32'd4102444800;
   // Epoch offset with the "day counts from 1" bias folded in.
   localparam logic [31:0] EPOCH_LESS_DAY = 32'd946598400;

   localparam logic [16:0] SEC_PER_DAY = 17'd86400;
   localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
   localparam logic [5:0] SEC_PER_MIN = 6'd60;
   localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;

   // Reciprocals for the estimate-then-correct constant dividers.
   localparam logic [22:0] RECIP_675 = 23'd6362914;
   localparam logic [8:0] RECIP_225 = 9'd291;
   localparam logic [13:0] RECIP_1461 = 14'd11483;
   localparam logic [12:0] RECIP_15 = 13'd4369;

   typedef struct packed {
      logic [NSTG-1:0] en;
   } pipe_ctrl_type;

   // Decode two BCD nibbles; nibbles above nine decode arithmetically.
   function automatic logic [7:0] bcd_decode(input logic [7:0] v);
      return ({4'b0, v[7:4]} * 8'd10) + {4'b0, v[3:0]};
   endfunction

   // Encode a value below 100 as two BCD digits.
   function automatic logic [7:0] bcd_encode(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      prod = {8'b0, v} * 15'd205;
      tens = prod[14:11];
      return {1'b0, v} + {2'b0, tens, 2'b0} + {3'b0, tens, 1'b0};
   endfunction

   // Days in the year before the first of a month.
   function automatic logic [8:0] cum_days(input logic [3:0] mon, input logic leap);
      logic [8:0] base;
      case (mon)
         4'd1: base = 9'd0;
         4'd2: base = 9'd31;
         4'd3: base = 9'd59;
         4'd4: base = 9'd90;
         4'd5: base = 9'd120;
         4'd6: base = 9'd151;
         4'd7: base = 9'd181;
         4'd8: base = 9'd212;
         4'd9: base = 9'd243;
         4'd10: base = 9'd273;
         4'd11: base = 9'd304;
         4'd12: base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + {8'b0, (leap && (mon > 4'd2))};
   endfunction

endpackage

### rtl/core/bcd_datetime_unix_time_converter.sv
// Top level of the BCD date/time to Unix seconds converter.
// Converts between real-time-clock register bytes (years 2000 to 2099) and 32-bit
// Unix seconds. With req_op low, the status bits of each register byte are masked, the
// BCD digits decoded (a nibble above nine decodes arithmetically), month and year are
// clamped with rsp_out_of_range set, and the Unix time is returned with all BCD fields
// zero. With req_op high, the timestamp is clamped to 2000-01-01 00:00:00 through
// 2099-12-31 23:59:59 (flag set when clamped) and split into BCD fields, with
// rsp_out_unix_time zero. The block is a ten-stage pipeline: it accepts one request
// per clock while req_ready is high, which it is unless every stage is full and the
// response is stalled. The depth is set by the chain of constant dividers in the
// split path (seconds per day, per hour, per minute and days per four-year cycle),
// each an estimate multiply, a back-multiply and a correction stage. A stalled
// response holds the last stage while earlier stages keep filling empty slots; no
// request is dropped or repeated.
module bcd_datetime_unix_time_converter
   import bdu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [31:0] req_in_unix_time,
   input  logic [7:0]  req_in_second_reg,
   input  logic [7:0]  req_in_minute_reg,
   input  logic [7:0]  req_in_hour_reg,
   input  logic [7:0]  req_in_day_reg,
   input  logic [7:0]  req_in_month_reg,
   input  logic [7:0]  req_in_year_reg,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_unix_time,
   output logic [6:0]  rsp_out_second_bcd,
   output logic [6:0]  rsp_out_minute_bcd,
   output logic [5:0]  rsp_out_hour_bcd,
   output logic [5:0]  rsp_out_day_bcd,
   output logic [4:0]  rsp_out_month_bcd,
   output logic [7:0]  rsp_out_year_bcd,
   output logic        rsp_out_of_range
);

   pipe_ctrl_type ctrl;
   logic          unix_flag;
   logic          bcd_flag;

   // Stage enables: advance a stage when it is empty or its request moves on.
   bdu_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   // Register bytes to Unix seconds; gives zero for split requests.
   bdu_to_unix u_to_unix (
      .clock             (clock),
      .ctrl              (ctrl),
      .req_op            (req_op),
      .req_in_second_reg (req_in_second_reg),
      .req_in_minute_reg (req_in_minute_reg),
      .req_in_hour_reg   (req_in_hour_reg),
      .req_in_day_reg    (req_in_day_reg),
      .req_in_month_reg  (req_in_month_reg),
      .req_in_year_reg   (req_in_year_reg),
      .unix_time         (rsp_out_unix_time),
      .flag              (unix_flag)
   );

   // Unix seconds to BCD fields; gives zero for register-decode requests.
   bdu_to_bcd u_to_bcd (
      .clock            (clock),
      .ctrl             (ctrl),
      .req_op           (req_op),
      .req_in_unix_time (req_in_unix_time),
      .second_bcd       (rsp_out_second_bcd),
      .minute_bcd       (rsp_out_minute_bcd),
      .hour_bcd         (rsp_out_hour_bcd),
      .day_bcd          (rsp_out_day_bcd),
      .month_bcd        (rsp_out_month_bcd),
      .year_bcd         (rsp_out_year_bcd),
      .flag             (bcd_flag)
   );

   // Each path gates its own flag by the request's op, so merge by OR.
   assign rsp_out_of_range = unix_flag | bcd_flag;

endmodule

### rtl/core/bdu_pipe_ctrl.sv
// Valid and stall control for the converter pipeline.
module bdu_pipe_ctrl
   import bdu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output pipe_ctrl_type ctrl
);

   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic [NSTG-1:0] en;

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      en[NSTG-1] = !valid_ff[NSTG-1] || rsp_ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[0] = en[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.en = en;
   assign req_ready = en[0];
   assign rsp_valid = valid_ff[NSTG-1];

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '0) |-> req_ready)
      else $error("empty pipeline refuses a request");

   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("pipeline stalls while the response side drains");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> valid_ff[0])
      else $error("accepted request did not enter the first stage");

   a_count: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(valid_ff) == $past($countones(valid_ff))
                + int'($past(req_valid && req_ready))
                - int'($past(rsp_valid && rsp_ready))))
      else $error("request lost or duplicated in the pipeline");

endmodule

### rtl/core/bdu_to_unix.sv
// Register bytes to Unix seconds datapath, padded to the full pipeline depth.
module bdu_to_unix
   import bdu_pkg::*;
(
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  logic          req_op,
   input  logic [7:0]    req_in_second_reg,
   input  logic [7:0]    req_in_minute_reg,
   input  logic [7:0]    req_in_hour_reg,
   input  logic [7:0]    req_in_day_reg,
   input  logic [7:0]    req_in_month_reg,
   input  logic [7:0]    req_in_year_reg,
   output logic [31:0]   unix_time,
   output logic          flag
);

   localparam int NDLY = NSTG - 3;

   logic       s1_op_ff, s1_flag_ff;
   logic [6:0] s1_sec_ff, s1_min_ff, s1_year_ff;
   logic [5:0] s1_hour_ff, s1_day_ff;
   logic [3:0] s1_mon_ff;

   logic [7:0] sec_dec, min_dec, hour_dec, day_dec, mon_dec, year_dec;
   logic [3:0] mon_in;
   logic [6:0] year_in;
   logic       flag_in;

   logic        s2_op_ff, s2_flag_ff;
   logic [15:0] s2_dsum_ff;
   logic [17:0] s2_tod_ff;
   logic [15:0] dsum_in;
   logic [17:0] tod_in;

   logic        s3_op_ff, s3_flag_ff;
   logic [31:0] s3_prod_ff;
   logic [17:0] s3_tod_ff;
   logic [31:0] prod_in;

   logic [31:0] s4_unix_in;
   logic        s4_flag_in;

   logic [31:0] dly_unix_ff [NDLY];
   logic        dly_flag_ff [NDLY];

   // Mask the status bits, decode BCD, clamp month and year.
   always_comb begin
      sec_dec = bcd_decode(req_in_second_reg & 8'h7F);
      min_dec = bcd_decode(req_in_minute_reg & 8'h7F);
      hour_dec = bcd_decode(req_in_hour_reg & 8'h3F);
      day_dec = bcd_decode(req_in_day_reg & 8'h3F);
      mon_dec = bcd_decode(req_in_month_reg & 8'h1F);
      year_dec = bcd_decode(req_in_year_reg);
      flag_in = 1'b0;
      mon_in = mon_dec[3:0];
      if (mon_dec == 8'd0) begin
         mon_in = 4'd1;
         flag_in = 1'b1;
      end else if (mon_dec > 8'd12) begin
         mon_in = 4'd12;
         flag_in = 1'b1;
      end
      year_in = year_dec[6:0];
      if (year_dec > 8'd99) begin
         year_in = 7'd99;
         flag_in = 1'b1;
      end
   end

   // Day count from 2000-01-01, biased by one, and seconds into the day.
   always_comb begin
      dsum_in = {10'b0, s1_day_ff}
              + {7'b0, cum_days(s1_mon_ff, (s1_year_ff[1:0] == 2'b00))}
              + ({9'b0, s1_year_ff} * 16'd365)
              + {9'b0, (7'(s1_year_ff + 7'd3) >> 2)};
      tod_in = ({12'b0, s1_hour_ff} * 18'(SEC_PER_HOUR))
             + ({11'b0, s1_min_ff} * 18'(SEC_PER_MIN))
             + {11'b0, s1_sec_ff};
   end

   assign prod_in = 32'({16'b0, s2_dsum_ff} * {15'b0, SEC_PER_DAY});

   always_comb begin
      s4_unix_in = s3_prod_ff + {14'b0, s3_tod_ff} + EPOCH_LESS_DAY;
      if (s3_op_ff) begin
         s4_unix_in = '0;
      end
      s4_flag_in = s3_flag_ff && !s3_op_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         s1_op_ff <= req_op;
         s1_flag_ff <= flag_in;
         s1_sec_ff <= sec_dec[6:0];
         s1_min_ff <= min_dec[6:0];
         s1_hour_ff <= hour_dec[5:0];
         s1_day_ff <= day_dec[5:0];
         s1_mon_ff <= mon_in;
         s1_year_ff <= year_in;
      end
      if (ctrl.en[1]) begin
         s2_op_ff <= s1_op_ff;
         s2_flag_ff <= s1_flag_ff;
         s2_dsum_ff <= dsum_in;
         s2_tod_ff <= tod_in;
      end
      if (ctrl.en[2]) begin
         s3_op_ff <= s2_op_ff;
         s3_flag_ff <= s2_flag_ff;
         s3_prod_ff <= prod_in;
         s3_tod_ff <= s2_tod_ff;
      end
      // Hold the finished result in step with the other datapath.
      if (ctrl.en[3]) begin
         dly_unix_ff[0] <= s4_unix_in;
         dly_flag_ff[0] <= s4_flag_in;
      end
      for (int k = 1; k < NDLY; k++) begin
         if (ctrl.en[3+k]) begin
            dly_unix_ff[k] <= dly_unix_ff[k-1];
            dly_flag_ff[k] <= dly_flag_ff[k-1];
         end
      end
   end

   assign unix_time = dly_unix_ff[NDLY-1];
   assign flag = dly_flag_ff[NDLY-1];

endmodule

### rtl/core/bdu_to_bcd.sv
// Unix seconds to BCD date/time datapath built from constant dividers.
module bdu_to_bcd
   import bdu_pkg::*;
(
   input  logic          clock,
   input  pipe_ctrl_type ctrl,
   input  logic          req_op,
   input  logic [31:0]   req_in_unix_time,
   output logic [6:0]    second_bcd,
   output logic [6:0]    minute_bcd,
   output logic [5:0]    hour_bcd,
   output logic [5:0]    day_bcd,
   output logic [4:0]    month_bcd,
   output logic [7:0]    year_bcd,
   output logic          flag
);

   // Stage 1: clamp and rebase to 2000.
   logic        s1_op_ff, s1_flag_ff;
   logic [31:0] s1_t_ff;
   logic [31:0] tclamp_in;
   logic        lo_in, hi_in;

   // Stage 2: day estimate.
   logic        s2_op_ff, s2_flag_ff;
   logic [31:0] s2_t_ff;
   logic [15:0] s2_dq_ff;
   logic [47:0] dq_prod;

   // Stage 3: raw seconds into the day.
   logic        s3_op_ff, s3_flag_ff;
   logic [15:0] s3_dq_ff;
   logic [17:0] s3_r_ff;
   logic [31:0] r_full;

   // Stage 4: corrected day and seconds of day.
   logic        s4_op_ff, s4_flag_ff;
   logic [15:0] s4_days_ff;
   logic [16:0] s4_rem_ff;

   // Stage 5: hour and four-year cycle estimates.
   logic        s5_op_ff, s5_flag_ff;
   logic [15:0] s5_days_ff;
   logic [16:0] s5_rem_ff;
   logic [4:0]  s5_h_ff, s5_c_ff;
   logic [21:0] h_prod;
   logic [29:0] c_prod;

   // Stage 6: raw remainders.
   logic        s6_op_ff, s6_flag_ff;
   logic [4:0]  s6_h_ff, s6_c_ff;
   logic [12:0] s6_rh_ff;
   logic [11:0] s6_rc_ff;
   logic [16:0] rh_full;
   logic [15:0] rc_full;

   // Stage 7: corrected hour and cycle.
   logic        s7_op_ff, s7_flag_ff;
   logic [4:0]  s7_hh_ff, s7_c_ff;
   logic [11:0] s7_rh_ff;
   logic [10:0] s7_dc_ff;

   // Stage 8: minute estimate, year and day of year.
   logic        s8_op_ff, s8_flag_ff;
   logic [4:0]  s8_hh_ff;
   logic [11:0] s8_rh_ff;
   logic [5:0]  s8_m_ff;
   logic [6:0]  s8_year_ff;
   logic [8:0]  s8_doy_ff;
   logic        s8_leap_ff;
   logic [22:0] m_prod;
   logic [1:0]  y4_in;
   logic [10:0] ystart_in;
   logic [10:0] doy_full;

   // Stage 9: raw seconds of minute, month and day of month.
   logic        s9_op_ff, s9_flag_ff;
   logic [4:0]  s9_hh_ff;
   logic [5:0]  s9_m_ff;
   logic [6:0]  s9_rm_ff;
   logic [6:0]  s9_year_ff;
   logic [3:0]  s9_mon_ff;
   logic [4:0]  s9_dom_ff;
   logic [11:0] rm_full;
   logic [3:0]  mon_in;
   logic [8:0]  dom_full;

   // Stage 10: output register.
   logic [6:0] sec_bcd_ff, min_bcd_ff;
   logic [5:0] hour_bcd_ff, day_bcd_ff;
   logic [4:0] mon_bcd_ff;
   logic [7:0] year_bcd_ff;
   logic       flag_ff;
   logic [5:0] mm_in;
   logic [6:0] ss_in;
   logic [7:0] enc_ss, enc_mm, enc_hh, enc_dd, enc_mo, enc_yy;

   always_comb begin
      lo_in = req_in_unix_time < EPOCH_2000;
      hi_in = req_in_unix_time >= END_2100;
      tclamp_in = req_in_unix_time;
      if (lo_in) begin
         tclamp_in = EPOCH_2000;
      end else if (hi_in) begin
         tclamp_in = END_2100 - 32'd1;
      end
   end

   // The estimates are exact or one low; a later stage checks the remainder and corrects them.
   assign dq_prod = {23'b0, s1_t_ff[31:7]} * {25'b0, RECIP_675};
   assign r_full = s2_t_ff - 32'({16'b0, s2_dq_ff} * {15'b0, SEC_PER_DAY});
   assign h_prod = {9'b0, s4_rem_ff[16:4]} * {13'b0, RECIP_225};
   assign c_prod = {14'b0, s4_days_ff} * {16'b0, RECIP_1461};
   assign rh_full = s5_rem_ff - 17'({12'b0, s5_h_ff} * {5'b0, SEC_PER_HOUR});
   assign rc_full = s5_days_ff - 16'({11'b0, s5_c_ff} * {5'b0, DAYS_PER_CYCLE});
   assign m_prod = {13'b0, s7_rh_ff[11:2]} * {10'b0, RECIP_15};
   assign rm_full = s8_rh_ff - 12'({6'b0, s8_m_ff} * {6'b0, SEC_PER_MIN});

   // Year within the four-year cycle; the first of the four is the leap year.
   always_comb begin
      if (s7_dc_ff < 11'd366) begin
         y4_in = 2'd0;
         ystart_in = 11'd0;
      end else if (s7_dc_ff < 11'd731) begin
         y4_in = 2'd1;
         ystart_in = 11'd366;
      end else if (s7_dc_ff < 11'd1096) begin
         y4_in = 2'd2;
         ystart_in = 11'd731;
      end else begin
         y4_in = 2'd3;
         ystart_in = 11'd1096;
      end
      doy_full = s7_dc_ff - ystart_in;
   end

   // Month is one plus the number of month starts already passed.
   always_comb begin
      mon_in = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         mon_in = mon_in + {3'b0, (s8_doy_ff >= cum_days(4'(k), s8_leap_ff))};
      end
      dom_full = s8_doy_ff - cum_days(mon_in, s8_leap_ff);
   end

   always_comb begin
      if (s9_rm_ff >= 7'(SEC_PER_MIN)) begin
         mm_in = s9_m_ff + 6'd1;
         ss_in = s9_rm_ff - 7'(SEC_PER_MIN);
      end else begin
         mm_in = s9_m_ff;
         ss_in = s9_rm_ff;
      end
      enc_ss = bcd_encode(ss_in);
      enc_mm = bcd_encode({1'b0, mm_in});
      enc_hh = bcd_encode({2'b0, s9_hh_ff});
      enc_dd = bcd_encode({2'b0, s9_dom_ff} + 7'd1);
      enc_mo = bcd_encode({3'b0, s9_mon_ff});
      enc_yy = bcd_encode(s9_year_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.en[0]) begin
         s1_op_ff <= req_op;
         s1_flag_ff <= lo_in || hi_in;
         s1_t_ff <= tclamp_in - EPOCH_2000;
      end
      if (ctrl.en[1]) begin
         s2_op_ff <= s1_op_ff;
         s2_flag_ff <= s1_flag_ff;
         s2_t_ff <= s1_t_ff;
         s2_dq_ff <= dq_prod[47:32];
      end
      if (ctrl.en[2]) begin
         s3_op_ff <= s2_op_ff;
         s3_flag_ff <= s2_flag_ff;
         s3_dq_ff <= s2_dq_ff;
         s3_r_ff <= r_full[17:0];
      end
      if (ctrl.en[3]) begin
         s4_op_ff <= s3_op_ff;
         s4_flag_ff <= s3_flag_ff;
         if (s3_r_ff >= {1'b0, SEC_PER_DAY}) begin
            s4_days_ff <= s3_dq_ff + 16'd1;
            s4_rem_ff <= 17'(s3_r_ff - {1'b0, SEC_PER_DAY});
         end else begin
            s4_days_ff <= s3_dq_ff;
            s4_rem_ff <= s3_r_ff[16:0];
         end
      end
      if (ctrl.en[4]) begin
         s5_op_ff <= s4_op_ff;
         s5_flag_ff <= s4_flag_ff;
         s5_days_ff <= s4_days_ff;
         s5_rem_ff <= s4_rem_ff;
         s5_h_ff <= h_prod[20:16];
         s5_c_ff <= c_prod[28:24];
      end
      if (ctrl.en[5]) begin
         s6_op_ff <= s5_op_ff;
         s6_flag_ff <= s5_flag_ff;
         s6_h_ff <= s5_h_ff;
         s6_c_ff <= s5_c_ff;
         s6_rh_ff <= rh_full[12:0];
         s6_rc_ff <= rc_full[11:0];
      end
      if (ctrl.en[6]) begin
         s7_op_ff <= s6_op_ff;
         s7_flag_ff <= s6_flag_ff;
         if (s6_rh_ff >= {1'b0, SEC_PER_HOUR}) begin
            s7_hh_ff <= s6_h_ff + 5'd1;
            s7_rh_ff <= 12'(s6_rh_ff - {1'b0, SEC_PER_HOUR});
         end else begin
            s7_hh_ff <= s6_h_ff;
            s7_rh_ff <= s6_rh_ff[11:0];
         end
         if (s6_rc_ff >= {1'b0, DAYS_PER_CYCLE}) begin
            s7_c_ff <= s6_c_ff + 5'd1;
            s7_dc_ff <= 11'(s6_rc_ff - {1'b0, DAYS_PER_CYCLE});
         end else begin
            s7_c_ff <= s6_c_ff;
            s7_dc_ff <= s6_rc_ff[10:0];
         end
      end
      if (ctrl.en[7]) begin
         s8_op_ff <= s7_op_ff;
         s8_flag_ff <= s7_flag_ff;
         s8_hh_ff <= s7_hh_ff;
         s8_rh_ff <= s7_rh_ff;
         s8_m_ff <= m_prod[21:16];
         s8_year_ff <= {s7_c_ff, 2'b00} + {5'b0, y4_in};
         s8_doy_ff <= doy_full[8:0];
         s8_leap_ff <= (y4_in == 2'd0);
      end
      if (ctrl.en[8]) begin
         s9_op_ff <= s8_op_ff;
         s9_flag_ff <= s8_flag_ff;
         s9_hh_ff <= s8_hh_ff;
         s9_m_ff <= s8_m_ff;
         s9_rm_ff <= rm_full[6:0];
         s9_year_ff <= s8_year_ff;
         s9_mon_ff <= mon_in;
         s9_dom_ff <= dom_full[4:0];
      end
      if (ctrl.en[9]) begin
         flag_ff <= s9_flag_ff && s9_op_ff;
         if (s9_op_ff) begin
            sec_bcd_ff <= enc_ss[6:0];
            min_bcd_ff <= enc_mm[6:0];
            hour_bcd_ff <= enc_hh[5:0];
            day_bcd_ff <= enc_dd[5:0];
            mon_bcd_ff <= enc_mo[4:0];
            year_bcd_ff <= enc_yy;
         end else begin
            sec_bcd_ff <= '0;
            min_bcd_ff <= '0;
            hour_bcd_ff <= '0;
            day_bcd_ff <= '0;
            mon_bcd_ff <= '0;
            year_bcd_ff <= '0;
         end
      end
   end

   assign second_bcd = sec_bcd_ff;
   assign minute_bcd = min_bcd_ff;
   assign hour_bcd = hour_bcd_ff;
   assign day_bcd = day_bcd_ff;
   assign month_bcd = mon_bcd_ff;
   assign year_bcd = year_bcd_ff;
   assign flag = flag_ff;

endmodule
